/* rtl/wlnf_pkg.sv */
// wlnf_pkg: shared types, constants and saturation helpers for the warped
// lattice noise filter. No dependencies; imported by all rtl but wlnf_ram.
`timescale 1ns / 1ps

package wlnf_pkg;

  // default sizes
  localparam int DEF_CHANNELS  = 8;
  localparam int DEF_MAX_ORDER = 64;

  // fixed point units and limits
  localparam logic [31:0] Q28_ONE   = 32'h1000_0000;
  localparam logic [31:0] Q30_ONE   = 32'h4000_0000;
  localparam logic [31:0] SAT_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN   = 32'h8000_0000;
  localparam logic [6:0]  ORDER_RST = 7'd64;

  // configuration register indexes
  localparam logic CFG_ORDER  = 1'b0;
  localparam logic CFG_LAMBDA = 1'b1;

  // operation codes
  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_INIT = 2'd1,
    OP_EVAL = 2'd2,
    OP_UPD  = 2'd3
  } op_e;

  // sequencer states
  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LAMSQ,
    ST_LAMSQ2,
    ST_RD,
    ST_I0,
    ST_I1,
    ST_I2,
    ST_I3,
    ST_E0,
    ST_E1,
    ST_E2,
    ST_E3,
    ST_E4,
    ST_E5,
    ST_E6,
    ST_U0,
    ST_U1,
    ST_DIVW,
    ST_EF1,
    ST_OUT
  } st_e;

  // rounded multiply request
  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic               sh28;
  } mul_req_t;

  // gain divide request
  typedef struct packed {
    logic        start;
    logic [31:0] o;
  } div_req_t;

  // sign extend to the common sum width
  function automatic logic [37:0] ext32(input logic [31:0] v);
    return {{6{v[31]}}, v};
  endfunction

  function automatic logic [37:0] ext36(input logic [35:0] v);
    return {{2{v[35]}}, v};
  endfunction

  // clamp a sum to the signed 32-bit range
  function automatic logic [31:0] sat32(input logic [37:0] v);
    logic [31:0] r;
    if (!v[37] && (|v[36:31])) begin
      r = SAT_MAX;
    end else if (v[37] && !(&v[36:31])) begin
      r = SAT_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* rtl/wlnf_ram.sv */
// wlnf_ram: single write port, single read port synchronous memory with a
// registered read. Depends on nothing.
`timescale 1ns / 1ps

module wlnf_ram #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/wlnf_mul.sv */
// wlnf_mul: signed 32x32 multiply, round to nearest and shift by 28 or 30,
// result registered. Depends on wlnf_pkg.
`timescale 1ns / 1ps

module wlnf_mul (
  input  logic              clk_i,
  input  wlnf_pkg::mul_req_t req_i,
  output logic [35:0]       p_o
);

  import wlnf_pkg::*;

  logic signed [63:0] prod;
  logic signed [65:0] sum;
  logic signed [65:0] shifted;
  logic [35:0]        p_q;

  // product plus half an lsb, then arithmetic shift
  assign prod    = req_i.a * req_i.b;
  assign sum     = $signed({{2{prod[63]}}, prod})
                 + (req_i.sh28 ? 66'sd134217728 : 66'sd536870912);
  assign shifted = req_i.sh28 ? (sum >>> 28) : (sum >>> 30);

  always_ff @(posedge clk_i) begin
    p_q <= shifted[35:0];
  end

  assign p_o = p_q;

endmodule

/* rtl/wlnf_div.sv */
// wlnf_div: bit-serial restoring divider that turns o into the gain -1/o,
// rounded and saturated to Q4.28. Depends on wlnf_pkg.
`timescale 1ns / 1ps

module wlnf_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wlnf_pkg::div_req_t req_i,
  output logic              done_o,
  output logic [31:0]       gain_o
);

  import wlnf_pkg::*;

  logic        busy_q, fin_q, done_q;
  logic [5:0]  cnt_q;
  logic [31:0] mag_q, rem_q, gain_q;
  logic        neg_q;
  logic [56:0] quo_q;

  logic [32:0] rem_sh, rem_sub;
  logic        fits;
  logic [32:0] half;
  logic [57:0] q_rnd;
  logic [32:0] q_clp;
  logic [32:0] q_neg;

  // one quotient bit a cycle, dividend is 2^56
  assign rem_sh  = {rem_q, (cnt_q == 6'd56)};
  assign fits    = rem_sh >= {1'b0, mag_q};
  assign rem_sub = rem_sh - {1'b0, mag_q};

  // round half up on the remainder, clamp at 2^31, apply sign
  assign half  = ({1'b0, mag_q} + 33'd1) >> 1;
  assign q_rnd = {1'b0, quo_q} + {57'd0, ({1'b0, rem_q} >= half)};
  assign q_clp = (q_rnd > 58'h0_8000_0000) ? 33'h0_8000_0000 : q_rnd[32:0];
  assign q_neg = ~q_clp + 33'd1;

  // control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd56;
      end else if (busy_q) begin
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 6'd1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mag_q <= req_i.o[31] ? (~req_i.o + 32'd1) : req_i.o;
      neg_q <= req_i.o[31];
      rem_q <= 32'd0;
      quo_q <= 57'd0;
    end else if (busy_q) begin
      rem_q <= fits ? rem_sub[31:0] : rem_sh[31:0];
      quo_q <= {quo_q[55:0], fits};
    end
    if (fin_q) begin
      if (neg_q) begin
        gain_q <= q_clp[31] ? SAT_MAX : q_clp[31:0];
      end else begin
        gain_q <= q_neg[31:0];
      end
    end
  end

  assign done_o = done_q;
  assign gain_o = gain_q;

endmodule

/* rtl/warped_lattice_noise_filter.sv */
// warped_lattice_noise_filter: top level, sequencer and per-channel gains.
// Depends on wlnf_pkg, wlnf_ram, wlnf_mul and wlnf_div.
//
// Usage: commands arrive on the s_axis channel, op in tuser, the rest in
// tdata. A load writes one coefficient, init clears one channel's lattice
// and computes its excitation and gain, evaluate returns one prediction on
// m_axis, update adds error times excitation into the state.
// The block works on one item at a time; s_axis_tready is high while idle.
// The evaluate loop is bound by the single shared multiplier, five products
// a tap, and the registered memory reads; the divide is one quotient bit a
// cycle. The prediction sits in an output register; the next item is
// accepted while it waits, and a later evaluate holds in its last step
// until the receiver takes the pending result.
// After reset a clearing pass writes zero to all three memories, one entry a
// cycle, CHANNELS*MAX_ORDER entries (512 at the defaults); tready stays low
// meanwhile. Configuration writes are taken at any time.
`timescale 1ns / 1ps

module warped_lattice_noise_filter #(
  parameter int CHANNELS  = wlnf_pkg::DEF_CHANNELS,
  parameter int MAX_ORDER = wlnf_pkg::DEF_MAX_ORDER
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [30:0] cfg_data_i,
  // command items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: channel[2:0], tap_index[8:3], coefficient[40:9], error_value[72:41]
  input  logic [79:0] s_axis_tdata,
  // tuser: op[1:0]
  input  logic [1:0]  s_axis_tuser,
  // prediction items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: prediction[31:0], out_channel[34:32]
  output logic [39:0] m_axis_tdata
);

  import wlnf_pkg::*;

  localparam int DEPTH = CHANNELS * MAX_ORDER;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TW    = $clog2(MAX_ORDER + 1);
  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // input fields
  logic [2:0]  in_ch;
  logic [5:0]  in_tap;
  logic [31:0] in_coef, in_err;
  logic        in_acc, ch_ok, tap_ok;
  logic [31:0] load_full;

  assign in_ch   = s_axis_tdata[2:0];
  assign in_tap  = s_axis_tdata[8:3];
  assign in_coef = s_axis_tdata[40:9];
  assign in_err  = s_axis_tdata[72:41];
  assign in_acc  = s_axis_tvalid & s_axis_tready;
  assign ch_ok   = 32'(in_ch) < CHANNELS;
  assign tap_ok  = 32'(in_tap) < MAX_ORDER;
  assign load_full = 32'(in_ch) * 32'(MAX_ORDER) + 32'(in_tap);

  // registers
  st_e         state_q, state_d;
  op_e         op_q;
  logic [2:0]  ch_q;
  logic [TW-1:0] t_q;
  logic [AW-1:0] clr_q;
  logic [31:0] err_q, o_q, u_q, tmp_q, oml2_q, res_q;
  logic [35:0] m_q;
  logic [6:0]  order_q;
  logic [30:0] warp_q;
  logic [31:0] gain_q [CHANNELS];
  logic        out_valid_q;
  logic [31:0] out_pred_q;
  logic [2:0]  out_ch_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= ORDER_RST;
      warp_q  <= 31'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ORDER:  order_q <= cfg_data_i[6:0];
        CFG_LAMBDA: warp_q  <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // derived settings
  logic [TW-1:0] n_c;
  logic [31:0]   lam, neg_lam;
  logic          more;
  assign n_c     = (32'(order_q) > MAX_ORDER) ? TW'(MAX_ORDER) : TW'(order_q);
  assign lam     = ({1'b0, warp_q} > Q30_ONE) ? Q30_ONE : {1'b0, warp_q};
  assign neg_lam = ~lam + 32'd1;
  assign more    = t_q < n_c;

  // memory address of the current tap
  logic [31:0]   addr_full;
  logic [AW-1:0] addr;
  logic [CW-1:0] ch_idx;
  logic [31:0]   gain_sel;
  assign addr_full = 32'(ch_q) * 32'(MAX_ORDER) + 32'(t_q);
  assign addr      = addr_full[AW-1:0];
  assign ch_idx    = CW'(ch_q);
  assign gain_sel  = gain_q[ch_idx];

  // memories and arithmetic units
  logic          c_we, s_we, x_we, rd_en;
  logic [AW-1:0] c_waddr, s_waddr;
  logic [31:0]   c_wdata, s_wdata, x_wdata;
  logic [31:0]   k_rd, a_rd, x_rd;
  logic [35:0]   p;
  mul_req_t      mreq;
  div_req_t      dreq;
  logic          div_done;
  logic [31:0]   div_gain;

  wlnf_ram #(.DEPTH(DEPTH), .AW(AW)) u_coef (
    .clk_i, .we_i(c_we), .waddr_i(c_waddr), .wdata_i(c_wdata),
    .re_i(rd_en), .raddr_i(addr), .rdata_o(k_rd)
  );

  wlnf_ram #(.DEPTH(DEPTH), .AW(AW)) u_state (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .re_i(rd_en), .raddr_i(addr), .rdata_o(a_rd)
  );

  wlnf_ram #(.DEPTH(DEPTH), .AW(AW)) u_exc (
    .clk_i, .we_i(x_we), .waddr_i(s_waddr), .wdata_i(x_wdata),
    .re_i(rd_en), .raddr_i(addr), .rdata_o(x_rd)
  );

  wlnf_mul u_mul (.clk_i, .req_i(mreq), .p_o(p));

  wlnf_div u_div (
    .clk_i, .rst_ni, .req_i(dreq), .done_o(div_done), .gain_o(div_gain)
  );

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state, multiplier operands, memory writes
  always_comb begin
    state_d    = state_q;
    mreq       = '0;
    dreq       = '0;
    rd_en      = 1'b0;
    c_we       = 1'b0;
    c_waddr    = load_full[AW-1:0];
    c_wdata    = in_coef;
    s_we       = 1'b0;
    s_waddr    = addr;
    s_wdata    = 32'd0;
    x_we       = 1'b0;
    x_wdata    = u_q;
    s_axis_tready = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        c_we    = 1'b1;
        s_we    = 1'b1;
        x_we    = 1'b1;
        c_waddr = clr_q;
        s_waddr = clr_q;
        c_wdata = 32'd0;
        x_wdata = 32'd0;
        if (clr_q == AW'(DEPTH - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_acc && ch_ok) begin
          unique case (op_e'(s_axis_tuser))
            OP_LOAD: c_we = tap_ok;
            OP_INIT: state_d = ST_RD;
            OP_EVAL: state_d = ST_LAMSQ;
            OP_UPD:  state_d = ST_RD;
            default: ;
          endcase
        end
      end
      ST_LAMSQ: begin
        mreq    = '{a: lam, b: lam, sh28: 1'b0};
        state_d = ST_LAMSQ2;
      end
      ST_LAMSQ2: state_d = ST_RD;
      ST_RD: begin
        if (more) begin
          rd_en = 1'b1;
          unique case (op_q)
            OP_INIT: begin
              s_we    = 1'b1;
              x_we    = 1'b1;
              state_d = ST_I0;
            end
            OP_EVAL: state_d = ST_E0;
            default: state_d = ST_U0;
          endcase
        end else begin
          unique case (op_q)
            OP_INIT: begin
              dreq    = '{start: (o_q != 32'd0), o: o_q};
              state_d = (o_q != 32'd0) ? ST_DIVW : ST_IDLE;
            end
            OP_EVAL: begin
              mreq    = '{a: o_q, b: gain_sel, sh28: 1'b1};
              state_d = ST_EF1;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      // init tap: u *= -lambda, A = u + k*o, o += k*u
      ST_I0: begin
        mreq    = '{a: u_q, b: neg_lam, sh28: 1'b0};
        state_d = ST_I1;
      end
      ST_I1: begin
        mreq    = '{a: k_rd, b: o_q, sh28: 1'b0};
        state_d = ST_I2;
      end
      ST_I2: begin
        mreq    = '{a: k_rd, b: u_q, sh28: 1'b0};
        state_d = ST_I3;
      end
      ST_I3: state_d = ST_RD;
      // evaluate tap: allpass section, then lattice stage
      ST_E0: begin
        mreq    = '{a: lam, b: a_rd, sh28: 1'b0};
        state_d = ST_E1;
      end
      ST_E1: begin
        s_we    = 1'b1;
        s_wdata = sat32(ext32(u_q) + ext36(p));
        mreq    = '{a: oml2_q, b: a_rd, sh28: 1'b0};
        state_d = ST_E2;
      end
      ST_E2: begin
        mreq    = '{a: lam, b: u_q, sh28: 1'b0};
        state_d = ST_E3;
      end
      ST_E3: state_d = ST_E4;
      ST_E4: begin
        mreq    = '{a: k_rd, b: u_q, sh28: 1'b0};
        state_d = ST_E5;
      end
      ST_E5: begin
        mreq    = '{a: k_rd, b: o_q, sh28: 1'b0};
        state_d = ST_E6;
      end
      ST_E6: state_d = ST_RD;
      // update tap: state += error * excitation
      ST_U0: begin
        mreq    = '{a: err_q, b: x_rd, sh28: 1'b1};
        state_d = ST_U1;
      end
      ST_U1: begin
        s_we    = 1'b1;
        s_wdata = sat32(ext32(a_rd) + ext36(p));
        state_d = ST_RD;
      end
      ST_DIVW: begin
        if (div_done) state_d = ST_IDLE;
      end
      ST_EF1: state_d = ST_OUT;
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // clearing pass counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (state_q == ST_CLEAR) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  // tap loop datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          op_q  <= op_e'(s_axis_tuser);
          ch_q  <= in_ch;
          err_q <= in_err;
          t_q   <= '0;
          if (op_e'(s_axis_tuser) == OP_INIT) begin
            o_q <= Q28_ONE;
            u_q <= Q28_ONE;
          end else begin
            o_q <= 32'd0;
            u_q <= 32'd0;
          end
        end
      end
      ST_LAMSQ2: oml2_q <= Q30_ONE - p[31:0];
      ST_I1:     u_q    <= sat32(ext36(p));
      ST_I2:     tmp_q  <= sat32(ext32(u_q) + ext36(p));
      ST_I3: begin
        o_q <= sat32(ext32(o_q) + ext36(p));
        u_q <= tmp_q;
        t_q <= t_q + TW'(1);
      end
      ST_E2:     m_q <= p;
      ST_E3:     u_q <= sat32(ext36(m_q) - ext36(p));
      ST_E5:     o_q <= sat32(ext32(o_q) + ext36(p));
      ST_E6: begin
        u_q <= sat32(ext32(u_q) + ext36(p));
        t_q <= t_q + TW'(1);
      end
      ST_U1:     t_q   <= t_q + TW'(1);
      ST_EF1:    res_q <= sat32(ext36(p));
      default: ;
    endcase
  end

  // per-channel gains
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) gain_q[i] <= Q28_ONE;
    end else if (state_q == ST_RD && op_q == OP_INIT && !more && o_q == 32'd0) begin
      gain_q[ch_idx] <= SAT_MIN;
    end else if (state_q == ST_DIVW && div_done) begin
      gain_q[ch_idx] <= div_gain;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_OUT && (!out_valid_q || m_axis_tready)) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && (!out_valid_q || m_axis_tready)) begin
      out_pred_q <= res_q;
      out_ch_q   <= ch_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_ch_q, out_pred_q};

endmodule

/* tb/tb.sv */
// tb: self-checking testbench for warped_lattice_noise_filter.
// Depends on wlnf_pkg and the rtl top; a built-in lattice predictor feeds a
// queue of expected predictions that the output monitor checks in order.
`timescale 1ns / 1ps

module tb;
  import wlnf_pkg::*;

  localparam int NCH   = 8;
  localparam int NTAP  = 64;
  localparam int DRAIN = 700;
  localparam longint ONE_Q28 = 64'sd268435456;
  localparam longint ONE_Q30 = 64'sd1073741824;

  typedef struct {
    logic [31:0] prediction;
    logic [2:0]  channel;
  } pred_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [30:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;

  // predictor copy of the block state
  int          coef_mem [NCH*NTAP];
  int          lat_mem  [NCH*NTAP];
  int          exc_mem  [NCH*NTAP];
  int          gain_mem [NCH];
  logic [6:0]  order_reg;
  logic [30:0] lambda_reg;

  pred_t       pending_q[$];
  pred_t       got;
  int          errors;
  int          items_sent;
  bit          no_idle;

  warped_lattice_noise_filter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // fixed point helpers
  function automatic longint clamp_q(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round_mul(input longint a, input longint b, input int s);
    return (a * b + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic int taps_active();
    return (order_reg > NTAP) ? NTAP : int'(order_reg);
  endfunction

  function automatic longint lambda_eff();
    return (longint'(lambda_reg) > ONE_Q30) ? ONE_Q30 : longint'(lambda_reg);
  endfunction

  // channel init: clear state, excitation vector and gain -1/o
  task automatic model_init(input int ch);
    longint o, u, a, k, lam;
    longint unsigned mag, q;
    int base;
    o = ONE_Q28;
    u = ONE_Q28;
    lam = lambda_eff();
    base = ch * NTAP;
    for (int t = 0; t < taps_active(); t++) begin
      k = coef_mem[base+t];
      lat_mem[base+t] = 0;
      exc_mem[base+t] = int'(u);
      u = clamp_q(round_mul(u, -lam, 30));
      a = clamp_q(u + round_mul(k, o, 30));
      o = clamp_q(o + round_mul(k, u, 30));
      u = a;
    end
    if (o == 0) begin
      gain_mem[ch] = 32'h8000_0000;
    end else begin
      mag = (o < 0) ? longint'(-o) : longint'(o);
      q = (64'd1 << 56) / mag;
      if ((64'd1 << 56) % mag >= (mag + 1) / 2) q++;
      if (q > (64'd1 << 31)) q = 64'd1 << 31;
      gain_mem[ch] = (o > 0) ? int'(clamp_q(-longint'(q))) : int'(clamp_q(longint'(q)));
    end
  endtask

  // warped lattice walk, returns the scaled prediction
  function automatic logic [31:0] model_eval(input int ch);
    longint lam, oml2, o, u, a, b, k;
    int base;
    lam = lambda_eff();
    oml2 = ONE_Q30 - round_mul(lam, lam, 30);
    o = 0;
    u = 0;
    base = ch * NTAP;
    for (int t = 0; t < taps_active(); t++) begin
      k = coef_mem[base+t];
      a = lat_mem[base+t];
      lat_mem[base+t] = int'(clamp_q(u + round_mul(lam, a, 30)));
      u = clamp_q(round_mul(oml2, a, 30) - round_mul(lam, u, 30));
      b = o;
      o = clamp_q(o + round_mul(k, u, 30));
      u = clamp_q(u + round_mul(k, b, 30));
    end
    return 32'(clamp_q(round_mul(o, gain_mem[ch], 28)));
  endfunction

  // apply one accepted item to the predictor
  task automatic model_item(input op_e op, input logic [2:0] ch, input logic [5:0] tap,
                            input logic [31:0] coef, input logic [31:0] err);
    int base;
    pred_t p;
    base = int'(ch) * NTAP;
    case (op)
      OP_LOAD: coef_mem[base+tap] = int'(coef);
      OP_INIT: model_init(int'(ch));
      OP_EVAL: begin
        p.prediction = model_eval(int'(ch));
        p.channel = ch;
        pending_q.push_back(p);
      end
      default: begin
        for (int t = 0; t < taps_active(); t++)
          lat_mem[base+t] = int'(clamp_q(longint'(lat_mem[base+t])
                            + round_mul(longint'($signed(err)), exc_mem[base+t], 28)));
      end
    endcase
  endtask

  task automatic report(input string what);
    $display("error at %0t: %s", $realtime, what);
    errors++;
  endtask

  // send one item with a random gap in front
  task automatic send_item(input op_e op, input logic [2:0] ch, input logic [5:0] tap,
                           input logic [31:0] coef, input logic [31:0] err);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'b0, err, coef, tap, ch};
    do @(posedge clk_i); while (!s_axis_tready);
    model_item(op, ch, tap, coef, err);
    items_sent++;
  endtask

  // hold off until every prediction is back and the block has settled
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic idx, input logic [30:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    if (idx == CFG_ORDER) order_reg = data[6:0];
    else lambda_reg = data;
  endtask

  task automatic set_config(input logic [6:0] ord, input logic [30:0] lam);
    drain();
    write_cfg(CFG_ORDER, {24'b0, ord});
    write_cfg(CFG_LAMBDA, lam);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coef();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return $urandom();
    return 32'($signed($urandom_range(0, 32'h7000_0000)) - 32'sh3800_0000);
  endfunction

  function automatic logic [31:0] rand_err();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return $urandom();
    return 32'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
  endfunction

  // extremes, every operation, zero o at init, order and lambda clamping
  task automatic test_directed();
    set_config(7'd4, 31'd0);
    send_item(OP_LOAD, 3'd0, 6'd0, 32'h7FFF_FFFF, 32'h0);
    send_item(OP_LOAD, 3'd0, 6'd1, 32'h8000_0000, 32'hFFFF_FFFF);
    send_item(OP_LOAD, 3'd0, 6'd2, 32'h2000_0000, 32'h0);
    send_item(OP_LOAD, 3'd0, 6'd63, 32'hE000_0000, 32'h0);
    send_item(OP_EVAL, 3'd7, 6'd0, 32'h0, 32'h0);
    send_item(OP_INIT, 3'd0, 6'd0, 32'h0, 32'h0);
    send_item(OP_UPD, 3'd0, 6'd0, 32'h0, 32'h7FFF_FFFF);
    send_item(OP_EVAL, 3'd0, 6'd0, 32'h0, 32'h0);
    send_item(OP_UPD, 3'd0, 6'd0, 32'h0, 32'h8000_0000);
    send_item(OP_EVAL, 3'd0, 6'd0, 32'h0, 32'h0);
    // zero o at init gives the most negative gain
    set_config(7'd1, 31'h4000_0000);
    send_item(OP_LOAD, 3'd1, 6'd0, 32'h4000_0000, 32'h0);
    send_item(OP_INIT, 3'd1, 6'd0, 32'h0, 32'h0);
    send_item(OP_UPD, 3'd1, 6'd0, 32'h0, 32'h0100_0000);
    send_item(OP_EVAL, 3'd1, 6'd0, 32'h0, 32'h0);
    // lambda above one and order above the tap count
    set_config(7'd127, 31'h7FFF_FFFF);
    send_item(OP_INIT, 3'd0, 6'd0, 32'h0, 32'h0);
    send_item(OP_UPD, 3'd0, 6'd0, 32'h0, 32'h0200_0000);
    send_item(OP_EVAL, 3'd0, 6'd0, 32'h0, 32'h0);
    // zero order
    set_config(7'd0, 31'h2000_0000);
    send_item(OP_INIT, 3'd2, 6'd0, 32'h0, 32'h0);
    send_item(OP_EVAL, 3'd2, 6'd0, 32'h0, 32'h0);
  endtask

  // load, init, then rounds of evaluate and update on one channel
  task automatic run_sequence();
    logic [2:0] ch;
    int n;
    int rounds;
    ch = 3'($urandom_range(0, 7));
    n = (taps_active() < 8) ? taps_active() : 8;
    for (int t = 0; t < n; t++)
      send_item(OP_LOAD, ch, 6'(t), rand_coef(), $urandom());
    if ($urandom_range(0, 7) == 0)
      send_item(OP_LOAD, ch, 6'($urandom_range(0, 63)), $urandom(), $urandom());
    send_item(OP_INIT, ch, 6'($urandom()), $urandom(), $urandom());
    rounds = $urandom_range(1, 6);
    for (int r = 0; r < rounds; r++) begin
      send_item(OP_EVAL, ch, 6'($urandom()), $urandom(), $urandom());
      send_item(OP_UPD, ch, 6'($urandom()), $urandom(), rand_err());
    end
  endtask

  task automatic send_noise();
    send_item(op_e'($urandom_range(0, 3)), 3'($urandom()), 6'($urandom()), $urandom(),
              $urandom());
  endtask

  // random phases over varied settings
  task automatic test_random();
    logic [6:0]  ord;
    logic [30:0] lam;
    int sel;
    while (items_sent < 1400) begin
      sel = $urandom_range(0, 9);
      ord = (sel == 0) ? 7'd64 : (sel == 1) ? 7'($urandom_range(65, 127)) :
            (sel == 2) ? 7'd0 : 7'($urandom_range(1, 8));
      sel = $urandom_range(0, 5);
      lam = (sel == 0) ? 31'd0 : (sel == 1) ? 31'h4000_0000 :
            (sel == 2) ? 31'($urandom_range(32'h4000_0001, 32'h7FFF_FFFF)) :
            31'($urandom_range(0, 32'h3FFF_FFFF));
      no_idle = ($urandom_range(0, 4) == 0);
      set_config(ord, lam);
      for (int s = 0; s < 4; s++) begin
        if ($urandom_range(0, 4) == 0) send_noise();
        else run_sequence();
      end
    end
    no_idle = 1'b0;
  endtask

  // sender waits for every prediction before going on
  task automatic test_pressure();
    set_config(7'd6, 31'h1800_0000);
    for (int i = 0; i < 10; i++) begin
      run_sequence();
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while (pending_q.size() != 0);
    end
  endtask

  // receiver with random stalls
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // check each prediction against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected prediction %h", m_axis_tdata));
      end else begin
        got = pending_q.pop_front();
        if (m_axis_tdata[31:0] !== got.prediction)
          report($sformatf("prediction %h, expected %h", m_axis_tdata[31:0], got.prediction));
        if (m_axis_tdata[34:32] !== got.channel)
          report($sformatf("channel %0d, expected %0d", m_axis_tdata[34:32], got.channel));
      end
    end
  end

  // run limit
  initial begin
    #100_000_000;
    $display("warped_lattice_noise_filter: mismatch");
    $finish;
  end

  // main sequence
  initial begin
    errors = 0;
    items_sent = 0;
    no_idle = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_ORDER;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_LOAD;
    for (int i = 0; i < NCH*NTAP; i++) begin
      coef_mem[i] = 0;
      lat_mem[i] = 0;
      exc_mem[i] = 0;
    end
    for (int i = 0; i < NCH; i++) gain_mem[i] = int'(ONE_Q28);
    order_reg = 7'd64;
    lambda_reg = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_pressure();
    test_random();
    drain();
    if (errors == 0) begin
      $display("warped_lattice_noise_filter: match");
    end else begin
      $display("warped_lattice_noise_filter: mismatch");
    end
    $finish;
  end

endmodule
